@@ hdl/bmp_pkg.sv @@
// Shared types, constants and the modular adder for the binomial mod-prime core.
`timescale 1ns / 1ps

package bmp_pkg;

    // Field widths fixed by the interface
    localparam int IDX_W  = 10;
    localparam int COEF_W = 14;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [COEF_W-1:0] coef_t;

    // Modulus and the edge value of every Pascal row
    localparam coef_t PRIME_MOD = 14'd10007;
    localparam coef_t COEF_ONE  = 14'd1;

    // (a + b) mod PRIME_MOD, both operands already reduced
    function automatic coef_t mod_add(input coef_t a, input coef_t b);
        logic [COEF_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, PRIME_MOD})
        begin
            sum = sum - {1'b0, PRIME_MOD};
        end
        return sum[COEF_W-1:0];
    endfunction

endpackage

@@ hdl/bmp_row_ram.sv @@
// Single-row scratch memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bmp_row_ram
    import bmp_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  coef_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output coef_t         rd_data
);

    coef_t mem [DEPTH];
    coef_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/binomial_mod_prime_pascal_core.sv @@
// Binomial coefficient C(n,k) mod 10007 built row by row in a scratch memory.
`timescale 1ns / 1ps
//
// Usage: drive row_n and choose_k and raise start while busy is low; that
// edge takes the query beat. busy stays high until the result is out. The
// result beat appears on coefficient for exactly one cycle with done high;
// the receiver must take it then, there is no back-pressure.
// Queries with choose_k > row_n, or choose_k at or beyond ROW_DEPTH, give 0:
// the core goes from S_IDLE straight to S_OUT. k = 0 gives 1 by way of
// S_INIT and S_FINAL. Otherwise the core rebuilds Pascal's triangle in the
// row memory: for each row i, S_ROW writes the diagonal one while i <= k,
// then S_WALK reads the entries downward to entry zero, one memory read per
// entry, and writes each new entry from the registered read data. The
// single read port of the row memory sets the pace: one entry per cycle.
// One query is handled at a time. Reset returns the core to idle; the row
// memory needs no clearing since every entry is written before it is read.
//
module binomial_mod_prime_pascal_core
    import bmp_pkg::*;
#(
    parameter int ROW_DEPTH = 1024
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  idx_t  row_n,
    input  idx_t  choose_k,
    output logic  done,
    output coef_t coefficient
);

    localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_ROW   = 6'b000100,
        S_WALK  = 6'b001000,
        S_FINAL = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    idx_t          n_reg, n_next;
    logic [AW-1:0] k_reg, k_next;
    idx_t          i_reg, i_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] da_reg, da_next;
    logic          iss_reg, iss_next;
    logic          rvld_reg, rvld_next;
    logic          first_reg, first_next;
    coef_t         upper_reg, upper_next;
    logic          zero_reg, zero_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    coef_t         wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    coef_t         rd_data;

    logic          k_in_range;
    logic          bad_query;
    logic          on_diag;
    logic [AW-1:0] row_top;
    logic [AW-1:0] first_addr;

    // row scratch memory
    bmp_row_ram #(
        .DEPTH (ROW_DEPTH),
        .AW    (AW)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // query screening
    assign k_in_range = CW'(choose_k) < CW'(ROW_DEPTH);
    assign bad_query  = (choose_k > row_n) || !k_in_range;

    // extent of the current row walk: entries top..1, diagonal set to one
    assign on_diag    = CW'(i_reg) <= CW'(k_reg);
    assign row_top    = on_diag ? AW'(i_reg) : k_reg;
    assign first_addr = on_diag ? row_top - AW'(1) : row_top;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        addr_next  = addr_reg;
        da_next    = da_reg;
        iss_next   = iss_reg;
        rvld_next  = 1'b0;
        first_next = first_reg;
        upper_next = upper_reg;
        zero_next  = zero_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = COEF_ONE;
        rd_en      = 1'b0;
        rd_addr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = row_n;
                    k_next     = AW'(choose_k);
                    zero_next  = bad_query;
                    state_next = bad_query ? S_OUT : S_INIT;
                end
            end
            S_INIT:
            begin
                // entry zero is one in every row
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = COEF_ONE;
                i_next  = IDX_W'(1);
                if ((n_reg == '0) || (k_reg == '0))
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (on_diag)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(i_reg);
                    wr_data = COEF_ONE;
                end
                addr_next  = first_addr;
                iss_next   = 1'b1;
                first_next = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // issue reads walking down to entry zero
                if (iss_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg;
                    addr_next = addr_reg - AW'(1);
                    iss_next  = (addr_reg != '0);
                    da_next   = addr_reg;
                end
                rvld_next = iss_reg;
                // consume read data: new[a+1] = old[a+1] + old[a]
                if (rvld_reg)
                begin
                    first_next = 1'b0;
                    upper_next = rd_data;
                    if (!first_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = da_reg + AW'(1);
                        wr_data = mod_add(upper_reg, rd_data);
                    end
                    if (da_reg == '0)
                    begin
                        if (i_reg == n_reg)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = S_ROW;
                        end
                    end
                end
            end
            S_FINAL:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            addr_reg  <= '0;
            da_reg    <= '0;
            iss_reg   <= 1'b0;
            rvld_reg  <= 1'b0;
            first_reg <= 1'b0;
            upper_reg <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            addr_reg  <= addr_next;
            da_reg    <= da_next;
            iss_reg   <= iss_next;
            rvld_reg  <= rvld_next;
            first_reg <= first_next;
            upper_reg <= upper_next;
            zero_reg  <= zero_next;
        end
    end

    // outputs
    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_OUT);
    assign coefficient = zero_reg ? '0 : rd_data;

    // checks
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a query");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted query did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("core not idle after result beat");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (coefficient < PRIME_MOD))
        else $error("coefficient not reduced");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("row memory read and write hit the same entry");

endmodule
